// ===== src/docfq_pkg.sv =====
package docfq_pkg;

    // Field and counter widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned MAG_W    = 17;
    localparam int unsigned LIMIT_W  = 15;
    localparam int unsigned ALERT_W  = 7;
    localparam int unsigned FORCE_W  = 8;
    localparam int unsigned LEVEL_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Limit reset values in milliamps.
    localparam logic [LIMIT_W-1:0] ALERT_LIMIT_RST = 15'd10500;
    localparam logic [LIMIT_W-1:0] FORCE_LIMIT_RST = 15'd14000;

    // Fault levels, ordered by severity.
    typedef enum logic [LEVEL_W-1:0] {
        LVL_SAFE    = 3'd0,
        LVL_WARNING = 3'd1,
        LVL_RISK    = 3'd2,
        LVL_DANGER  = 3'd3,
        LVL_DEADLY  = 3'd4
    } level_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_ALERT = 2'd0,
        CFG_SRC_FORCE = 2'd1,
        CFG_CAP_ALERT = 2'd2,
        CFG_CAP_FORCE = 2'd3
    } cfg_index_t;

    // Status that a channel hands to the fusion logic.
    typedef struct packed {
        level_t level_next;
    } chan_status_t;

endpackage

// ===== src/docfq_sample_if.sv =====
interface docfq_sample_if;
    logic                                      valid;
    logic                                      ready;
    logic signed [docfq_pkg::SAMPLE_W-1:0]     source_current_ma;
    logic signed [docfq_pkg::SAMPLE_W-1:0]     cap_current_ma;

    modport source (output valid, output source_current_ma, output cap_current_ma,
                    input ready);
    modport sink   (input valid, input source_current_ma, input cap_current_ma,
                    output ready);
endinterface

// ===== src/docfq_result_if.sv =====
interface docfq_result_if;
    logic                              valid;
    logic                              ready;
    logic [docfq_pkg::LEVEL_W-1:0]     fault_level;
    logic                              level_changed;
    logic                              silence_request;
    logic                              record_fault;
    logic                              restore_request;

    modport source (output valid, output fault_level, output level_changed,
                    output silence_request, output record_fault,
                    output restore_request, input ready);
    modport sink   (input valid, input fault_level, input level_changed,
                    input silence_request, input record_fault,
                    input restore_request, output ready);
endinterface

// ===== src/docfq_chan.sv =====
module docfq_chan #(
    parameter int unsigned ALERT_SPAN = 100,
    parameter int unsigned FORCE_SPAN = 150
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   update,
    input  logic signed [docfq_pkg::SAMPLE_W-1:0]  sample,
    input  logic [docfq_pkg::LIMIT_W-1:0]          alert_limit,
    input  logic [docfq_pkg::LIMIT_W-1:0]          force_limit,
    output docfq_pkg::chan_status_t                status
);

    localparam logic [docfq_pkg::ALERT_W-1:0] ALERT_TOP = docfq_pkg::ALERT_W'(ALERT_SPAN);
    localparam logic [docfq_pkg::FORCE_W-1:0] FORCE_TOP = docfq_pkg::FORCE_W'(FORCE_SPAN);

    logic [docfq_pkg::ALERT_W-1:0] alert_cnt_reg;
    logic [docfq_pkg::ALERT_W-1:0] alert_cnt_next;
    logic [docfq_pkg::FORCE_W-1:0] force_cnt_reg;
    logic [docfq_pkg::FORCE_W-1:0] force_cnt_next;
    docfq_pkg::level_t             level_reg;
    docfq_pkg::level_t             level_alert;
    docfq_pkg::level_t             level_next;

    logic [docfq_pkg::MAG_W-1:0]   sample_ext;
    logic [docfq_pkg::MAG_W-1:0]   mag;
    logic [docfq_pkg::MAG_W-1:0]   alert_ext;
    logic [docfq_pkg::MAG_W-1:0]   force_ext;
    logic                          below_alert;
    logic                          below_force;

    // Magnitude at 17 bits so that the most negative sample needs no saturation.
    assign sample_ext  = docfq_pkg::MAG_W'(sample);
    assign mag         = sample[docfq_pkg::SAMPLE_W-1] ? (~sample_ext + 1'b1) : sample_ext;
    assign alert_ext   = docfq_pkg::MAG_W'(alert_limit);
    assign force_ext   = docfq_pkg::MAG_W'(force_limit);
    assign below_alert = mag < alert_ext;
    assign below_force = mag < force_ext;

    // Alert counter: first matching rule wins.
    always_comb
    begin
        priority if (below_alert && alert_cnt_reg != '0)
        begin
            alert_cnt_next = alert_cnt_reg - 1'b1;
        end
        else if (!below_alert && below_force && alert_cnt_reg < ALERT_TOP)
        begin
            alert_cnt_next = alert_cnt_reg + 1'b1;
        end
        else if (!below_force)
        begin
            alert_cnt_next = ALERT_TOP;
        end
        else
        begin
            alert_cnt_next = alert_cnt_reg;
        end
    end

    // Level with hysteresis from the new alert count.
    always_comb
    begin
        priority if (alert_cnt_next == '0 && level_reg != docfq_pkg::LVL_SAFE)
        begin
            level_alert = docfq_pkg::LVL_SAFE;
        end
        else if (alert_cnt_next != '0 && alert_cnt_next < ALERT_TOP
                 && level_reg < docfq_pkg::LVL_WARNING)
        begin
            level_alert = docfq_pkg::LVL_WARNING;
        end
        else if (alert_cnt_next == ALERT_TOP && level_reg < docfq_pkg::LVL_RISK)
        begin
            level_alert = docfq_pkg::LVL_RISK;
        end
        else
        begin
            level_alert = level_reg;
        end
    end

    // Force counter runs up at Risk and decays below it; full span is deadly.
    always_comb
    begin
        priority if (level_alert == docfq_pkg::LVL_RISK && force_cnt_reg < FORCE_TOP)
        begin
            force_cnt_next = force_cnt_reg + 1'b1;
        end
        else if (level_alert < docfq_pkg::LVL_RISK && force_cnt_reg != '0)
        begin
            force_cnt_next = force_cnt_reg - 1'b1;
        end
        else
        begin
            force_cnt_next = force_cnt_reg;
        end
        level_next = (force_cnt_next == FORCE_TOP) ? docfq_pkg::LVL_DEADLY : level_alert;
    end

    assign status.level_next = level_next;

    // Channel state advances only for items that are processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alert_cnt_reg <= '0;
            force_cnt_reg <= '0;
            level_reg     <= docfq_pkg::LVL_SAFE;
        end
        else if (update)
        begin
            alert_cnt_reg <= alert_cnt_next;
            force_cnt_reg <= force_cnt_next;
            level_reg     <= level_next;
        end
    end

endmodule

// ===== src/dual_overcurrent_fault_qualifier.sv =====
// Dual overcurrent fault qualifier.
// The sample_in channel takes one pair of signed milliamp samples (source and
// capacitor current) per transfer; the result_out channel gives one result per
// sample: the fused fault level and the level_changed, silence_request,
// record_fault and restore_request pulses for that sample.
// The result of a sample accepted at a clock edge is registered and is valid
// right after that edge. Throughput is one sample per cycle while the
// receiver takes results; the channel counters and levels are updated in a
// single pass between the input handshake and the result register.
// The limit registers are written through cfg_we, cfg_index and cfg_data and
// should only change while no result is pending.
// Reset clears both channels to Safe with zero counts, restores the default
// limits and empties the result register. When the receiver stalls, the
// result register holds its value and sample_in.ready drops until the result
// is taken. Once the fused level reaches Deadliness the block freezes and
// reports Deadliness for every further sample until reset.
module dual_overcurrent_fault_qualifier #(
    parameter int unsigned ALERT_SPAN = 100,
    parameter int unsigned FORCE_SPAN = 150
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    docfq_sample_if.sink                          sample_in,
    docfq_result_if.source                        result_out,
    input  logic                                  cfg_we,
    input  logic [docfq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [docfq_pkg::LIMIT_W-1:0]         cfg_data
);

    logic [docfq_pkg::LIMIT_W-1:0] src_alert_limit_reg;
    logic [docfq_pkg::LIMIT_W-1:0] src_force_limit_reg;
    logic [docfq_pkg::LIMIT_W-1:0] cap_alert_limit_reg;
    logic [docfq_pkg::LIMIT_W-1:0] cap_force_limit_reg;

    docfq_pkg::level_t             fused_level_reg;
    docfq_pkg::level_t             fused_level_next;
    docfq_pkg::chan_status_t       src_status;
    docfq_pkg::chan_status_t       cap_status;

    logic                          out_valid_reg;
    docfq_pkg::level_t             out_level_reg;
    logic                          out_changed_reg;
    logic                          out_silence_reg;
    logic                          out_record_reg;
    logic                          out_restore_reg;

    logic                          accept;
    logic                          frozen;
    logic                          update;
    logic                          changed;
    logic                          silence;
    logic                          record;
    logic                          restore;

    // Handshake: the result register parts the two sides.
    assign sample_in.ready = !out_valid_reg || result_out.ready;
    assign accept          = sample_in.valid && sample_in.ready;
    assign frozen          = fused_level_reg == docfq_pkg::LVL_DEADLY;
    assign update          = accept && !frozen;

    // Limit registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_alert_limit_reg <= docfq_pkg::ALERT_LIMIT_RST;
            src_force_limit_reg <= docfq_pkg::FORCE_LIMIT_RST;
            cap_alert_limit_reg <= docfq_pkg::ALERT_LIMIT_RST;
            cap_force_limit_reg <= docfq_pkg::FORCE_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (docfq_pkg::cfg_index_t'(cfg_index))
                docfq_pkg::CFG_SRC_ALERT: src_alert_limit_reg <= cfg_data;
                docfq_pkg::CFG_SRC_FORCE: src_force_limit_reg <= cfg_data;
                docfq_pkg::CFG_CAP_ALERT: cap_alert_limit_reg <= cfg_data;
                docfq_pkg::CFG_CAP_FORCE: cap_force_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Per-channel counters and levels.
    docfq_chan #(
        .ALERT_SPAN (ALERT_SPAN),
        .FORCE_SPAN (FORCE_SPAN)
    ) u_src_chan (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (update),
        .sample      (sample_in.source_current_ma),
        .alert_limit (src_alert_limit_reg),
        .force_limit (src_force_limit_reg),
        .status      (src_status)
    );

    docfq_chan #(
        .ALERT_SPAN (ALERT_SPAN),
        .FORCE_SPAN (FORCE_SPAN)
    ) u_cap_chan (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (update),
        .sample      (sample_in.cap_current_ma),
        .alert_limit (cap_alert_limit_reg),
        .force_limit (cap_force_limit_reg),
        .status      (cap_status)
    );

    // Fused level is the more severe channel; transitions raise pulses.
    always_comb
    begin
        fused_level_next = (src_status.level_next >= cap_status.level_next)
                           ? src_status.level_next : cap_status.level_next;
        changed = 1'b0;
        silence = 1'b0;
        record  = 1'b0;
        restore = 1'b0;
        if (!frozen && fused_level_next != fused_level_reg)
        begin
            changed = 1'b1;
            priority if (fused_level_reg <= docfq_pkg::LVL_WARNING)
            begin
                silence = fused_level_next == docfq_pkg::LVL_RISK
                          || fused_level_next == docfq_pkg::LVL_DEADLY;
                record  = fused_level_next == docfq_pkg::LVL_DEADLY;
            end
            else if (fused_level_reg == docfq_pkg::LVL_RISK)
            begin
                restore = fused_level_next <= docfq_pkg::LVL_WARNING;
                record  = fused_level_next == docfq_pkg::LVL_DEADLY;
            end
            else
            begin
                silence = 1'b0;
            end
        end
    end

    // Fused level state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fused_level_reg <= docfq_pkg::LVL_SAFE;
        end
        else if (update)
        begin
            fused_level_reg <= fused_level_next;
        end
    end

    // Result register: loaded on every transfer in, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_level_reg   <= frozen ? docfq_pkg::LVL_DEADLY : fused_level_next;
            out_changed_reg <= changed;
            out_silence_reg <= silence;
            out_record_reg  <= record;
            out_restore_reg <= restore;
        end
    end

    assign result_out.valid           = out_valid_reg;
    assign result_out.fault_level     = out_level_reg;
    assign result_out.level_changed   = out_changed_reg;
    assign result_out.silence_request = out_silence_reg;
    assign result_out.record_fault    = out_record_reg;
    assign result_out.restore_request = out_restore_reg;

endmodule
